### hw/rtl/mpq_pkg.sv
// Shared constants, types and functions of the archive block decryptor.
package mpq_pkg;

    localparam int WORD_W      = 32;
    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int TABLE_BANKS = 5;

    localparam logic [WORD_W-1:0] SEED_INIT = 32'hEEEE_EEEE;
    localparam logic [WORD_W-1:0] KEY_ADD   = 32'h1111_1111;
    localparam logic [WORD_W-1:0] KEY_XOR   = 32'h0000_07FF;
    localparam logic [WORD_W-1:0] SEED_INC  = 32'h0000_0003;
    localparam logic [WORD_W-1:0] LCG_START = 32'h0010_0001;
    localparam logic [WORD_W-1:0] LCG_MUL   = 32'd125;
    localparam logic [WORD_W-1:0] LCG_ADD   = 32'd3;
    localparam logic [WORD_W-1:0] LCG_MOD   = 32'h002A_AAAB;

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t table_t [TABLE_DEPTH];

    // Advance the key by one word.
    function automatic word_t key_update(input word_t key);
        word_t shifted;
        shifted = (key ^ KEY_XOR) << 21;
        return (key >> 11) | (KEY_ADD + shifted);
    endfunction

    // One step of the table generator.
    function automatic word_t lcg_next(input word_t s);
        return (s * LCG_MUL + LCG_ADD) % LCG_MOD;
    endfunction

    // Build the crypt table at elaboration; keep only the last bank.
    function automatic table_t build_table();
        table_t tbl;
        word_t  s;
        word_t  hi;
        word_t  lo;
        s = LCG_START;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            for (int j = 0; j < TABLE_BANKS; j++) begin
                s  = lcg_next(s);
                hi = {s[15:0], 16'h0000};
                s  = lcg_next(s);
                lo = {16'h0000, s[15:0]};
                if (j == TABLE_BANKS - 1) begin
                    tbl[i] = hi | lo;
                end
            end
        end
        return tbl;
    endfunction

endpackage

### hw/rtl/mpq_if.sv
// Valid/ready channel interfaces for cipher requests and plain results.
interface mpq_in_if;
    logic                         valid;
    logic                         ready;
    logic [mpq_pkg::WORD_W-1:0]   cipher_word;
    logic [mpq_pkg::WORD_W-1:0]   block_key;
    logic                         start_of_block;

    modport source (output valid, output cipher_word, output block_key,
                    output start_of_block, input ready);
    modport sink   (input valid, input cipher_word, input block_key,
                    input start_of_block, output ready);
endinterface

interface mpq_out_if;
    logic                         valid;
    logic                         ready;
    logic [mpq_pkg::WORD_W-1:0]   plain_word;

    modport source (output valid, output plain_word, input ready);
    modport sink   (input valid, input plain_word, output ready);
endinterface

### hw/rtl/mpq_block_decrypt.sv
// Top level: decrypts a stream of archive words, one request per cycle if not stalled.
// An accepted request is registered in the mix stage, then in the output register.
// One word per cycle unless stalled: the mix stage seed add chain closes the loop.
// The crypt table is a 256-entry ROM read on accept, addressed by the key byte.
// Reset clears the pipeline, sets the seed to 0xEEEEEEEE and the key to zero.
module mpq_block_decrypt (
    input  logic        clk,
    input  logic        rst_n,
    mpq_in_if.sink      inbound,
    mpq_out_if.source   outbound
);

    localparam mpq_pkg::table_t CRYPT_TABLE = mpq_pkg::build_table();

    // Key stage state
    mpq_pkg::word_t key_reg;
    mpq_pkg::word_t key_sel;
    mpq_pkg::word_t key_next;

    // Mix stage
    logic           s2_valid_reg;
    logic           s2_start_reg;
    mpq_pkg::word_t s2_cipher_reg;
    mpq_pkg::word_t s2_key_reg;
    mpq_pkg::word_t tbl_data_reg;
    mpq_pkg::word_t seed_reg;
    mpq_pkg::word_t seed_base;
    mpq_pkg::word_t seed_mix;
    mpq_pkg::word_t plain_calc;
    mpq_pkg::word_t seed_next;

    // Output register
    logic           out_valid_reg;
    mpq_pkg::word_t out_plain_reg;

    logic           accept;
    logic           advance;

    // Handshake
    assign advance       = s2_valid_reg && (!out_valid_reg || outbound.ready);
    assign inbound.ready = !s2_valid_reg || advance;
    assign accept        = inbound.valid && inbound.ready;

    // Select the key for this word and step it for the next one
    always_comb
    begin
        key_sel  = inbound.start_of_block ? inbound.block_key : key_reg;
        key_next = mpq_pkg::key_update(key_sel);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (accept)
        begin
            key_reg <= key_next;
        end
    end

    // Read the table and load the mix stage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tbl_data_reg  <= CRYPT_TABLE[key_sel[mpq_pkg::ADDR_W-1:0]];
            s2_cipher_reg <= inbound.cipher_word;
            s2_key_reg    <= key_sel;
            s2_start_reg  <= inbound.start_of_block;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (inbound.ready)
        begin
            s2_valid_reg <= inbound.valid;
        end
    end

    // Mix the seed and recover the plaintext
    always_comb
    begin
        seed_base  = s2_start_reg ? mpq_pkg::SEED_INIT : seed_reg;
        seed_mix   = seed_base + tbl_data_reg;
        plain_calc = s2_cipher_reg ^ (seed_mix + s2_key_reg);
        seed_next  = seed_mix + plain_calc + (seed_mix << 5) + mpq_pkg::SEED_INC;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= mpq_pkg::SEED_INIT;
        end
        else if (advance)
        begin
            seed_reg <= seed_next;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (outbound.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_plain_reg <= plain_calc;
        end
    end

    assign outbound.valid      = out_valid_reg;
    assign outbound.plain_word = out_plain_reg;

`ifndef SYNTHESIS
    // A block start carries its own key into the mix stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && inbound.start_of_block) |=> (s2_key_reg == $past(inbound.block_key)))
        else $error("block key not loaded into mix stage");

    // The seed moves only when a word leaves the mix stage
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(seed_reg))
        else $error("seed changed without a word advancing");

    // An advancing word lands in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_valid_reg && out_plain_reg == $past(plain_calc)))
        else $error("result lost on its way to the output register");

    // A stalled mix stage keeps its table data
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !advance) |=> $stable(tbl_data_reg))
        else $error("table data changed under a stalled word");
`endif

endmodule
